// ===== src/iie_bank_switch_mmu_unit_assert.svh =====
// Assertion macros used by the checker file of the bank-switch MMU.
`ifndef IIE_BANK_SWITCH_MMU_UNIT_ASSERT_SVH
`define IIE_BANK_SWITCH_MMU_UNIT_ASSERT_SVH

// Condition must hold in the same cycle as the antecedent.
`define IIE_BSM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Condition must hold in the cycle after the antecedent.
`define IIE_BSM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/iie_bsm_pkg.sv =====
package iie_bsm_pkg;

    // Bank codes reported for each access
    typedef enum logic [2:0] {
        BANK_MAIN    = 3'd0,
        BANK_LC      = 3'd1,
        BANK_LC2     = 3'd2,
        BANK_AUX     = 3'd3,
        BANK_AUX_LC  = 3'd4,
        BANK_AUX_LC2 = 3'd5,
        BANK_ROM     = 3'd6,
        BANK_CARD    = 3'd7
    } bank_t;

    // Access classes
    typedef enum logic [2:0] {
        KIND_MEMORY    = 3'd0,
        KIND_SWITCH    = 3'd1,
        KIND_STATUS    = 3'd2,
        KIND_FLOATING  = 3'd3,
        KIND_SLOT_IO   = 3'd4,
        KIND_DEVICE    = 3'd5,
        KIND_UNHANDLED = 3'd6
    } kind_t;

    // Soft-switch and language-card state
    typedef struct packed {
        logic alt_zero_page;
        logic display_page2;
        logic store_80;
        logic hires_mode;
        logic aux_read;
        logic aux_write;
        logic internal_cx_rom;
        logic slot_c3_rom;
        logic card_expansion_rom;
        logic lc_read_ram;
        logic lc_write_ram;
        logic lc_bank2;
    } state_t;

    // One decoded result
    typedef struct packed {
        bank_t      target_bank;
        logic       write_blocked;
        kind_t      access_kind;
        logic       status_bit;
        logic [2:0] slot_index;
    } result_t;

    localparam state_t STATE_RESET = '{
        alt_zero_page:      1'b0,
        display_page2:      1'b0,
        store_80:           1'b0,
        hires_mode:         1'b0,
        aux_read:           1'b0,
        aux_write:          1'b0,
        internal_cx_rom:    1'b0,
        slot_c3_rom:        1'b0,
        card_expansion_rom: 1'b0,
        lc_read_ram:        1'b0,
        lc_write_ram:       1'b1,
        lc_bank2:           1'b1
    };

    // Address constants
    localparam logic [15:0] ADDR_CX_RELEASE = 16'hCFFF;
    localparam logic [7:0]  PAGE_IO         = 8'hC0;
    localparam logic [7:0]  PAGE_ROM_FIRST  = 8'hC1;
    localparam logic [7:0]  PAGE_C3         = 8'hC3;
    localparam logic [7:0]  PAGE_SLOT_LAST  = 8'hC7;
    localparam logic [7:0]  PAGE_LC         = 8'hD0;
    localparam logic [7:0]  PAGE_LC_UPPER   = 8'hE0;
    localparam logic [7:0]  IO_LC_FIRST     = 8'h80;
    localparam logic [7:0]  IO_SLOT_FIRST   = 8'h90;
    localparam logic [7:0]  IO_SWITCH_END   = 8'h0C;

    // Language-card mode tables, indexed by mode bits [1:0]
    localparam logic [3:0] LC_RD_TAB = 4'b1001;
    localparam logic [3:0] LC_WR_TAB = 4'b1010;

    // Result word layout on the output channel
    localparam int RES_BANK_LSB    = 0;
    localparam int RES_BLOCKED_BIT = 3;
    localparam int RES_KIND_LSB    = 4;
    localparam int RES_STATUS_BIT  = 7;
    localparam int RES_SLOT_LSB    = 8;

endpackage

// ===== src/iie_bsm_decode.sv =====
module iie_bsm_decode (
    input  iie_bsm_pkg::state_t  state_cur,
    input  logic                 opcode,
    input  logic [15:0]          address,
    input  logic                 is_write,
    output iie_bsm_pkg::result_t result,
    output iie_bsm_pkg::state_t  state_next
);
    import iie_bsm_pkg::*;

    // Map a non-I/O page to its bank for the given direction
    function automatic bank_t map_bank(input logic [7:0] pg, input logic wr,
                                       input state_t s);
        bank_t b;
        logic  lc_en;
        logic  upper2;
        b      = BANK_MAIN;
        lc_en  = wr ? s.lc_write_ram : s.lc_read_ram;
        upper2 = (pg < PAGE_LC_UPPER) && s.lc_bank2;
        if (pg >= PAGE_LC) begin
            if (!lc_en) begin
                b = BANK_ROM;
            end else if (s.alt_zero_page) begin
                b = upper2 ? BANK_AUX_LC2 : BANK_AUX_LC;
            end else begin
                b = upper2 ? BANK_LC2 : BANK_LC;
            end
        end else if (pg >= PAGE_ROM_FIRST) begin
            if (wr) begin
                b = BANK_ROM;
            end else if (pg == PAGE_C3) begin
                b = (!s.internal_cx_rom && s.slot_c3_rom) ? BANK_CARD : BANK_ROM;
            end else if (pg <= PAGE_SLOT_LAST) begin
                b = s.internal_cx_rom ? BANK_ROM : BANK_CARD;
            end else begin
                b = (!s.internal_cx_rom && s.card_expansion_rom) ? BANK_CARD : BANK_ROM;
            end
        end else if (pg == PAGE_IO) begin
            b = BANK_MAIN;
        end else if (pg < 8'h02) begin
            b = s.alt_zero_page ? BANK_AUX : BANK_MAIN;
        end else if (s.store_80 && ((pg >= 8'h04 && pg <= 8'h07) ||
                     (s.hires_mode && pg >= 8'h20 && pg <= 8'h3F))) begin
            b = s.display_page2 ? BANK_AUX : BANK_MAIN;
        end else begin
            b = (wr ? s.aux_write : s.aux_read) ? BANK_AUX : BANK_MAIN;
        end
        return b;
    endfunction

    logic [7:0] pg;
    logic [7:0] lo;
    logic       on;
    bank_t      bank;

    assign pg   = address[15:8];
    assign lo   = address[7:0];
    assign on   = address[0];
    assign bank = map_bank(pg, is_write, state_cur);

    // Decode one access and work out the state it leaves
    always_comb begin
        result     = '0;
        state_next = state_cur;
        if (opcode) begin
            state_next.card_expansion_rom = 1'b1;
        end else if (pg == PAGE_IO) begin
            if ((lo == 8'h00 && !is_write) || lo == 8'h10 ||
                (lo >= 8'h61 && lo <= 8'h63)) begin
                result.access_kind = KIND_DEVICE;
            end else if (lo >= IO_SLOT_FIRST) begin
                result.access_kind = KIND_SLOT_IO;
                result.slot_index  = address[6:4] - 3'd1;
            end else if (lo >= IO_LC_FIRST) begin
                result.access_kind     = KIND_SWITCH;
                state_next.lc_read_ram  = LC_RD_TAB[address[1:0]];
                state_next.lc_write_ram = LC_WR_TAB[address[1:0]];
                state_next.lc_bank2     = ~address[3];
            end else if (lo == 8'h54 || lo == 8'h55) begin
                result.access_kind       = KIND_SWITCH;
                state_next.display_page2 = on;
            end else if (lo == 8'h56 || lo == 8'h57) begin
                result.access_kind    = KIND_SWITCH;
                state_next.hires_mode = on;
            end else if (lo == 8'h30 || (lo >= 8'h64 && lo <= 8'h68) || lo == 8'h70) begin
                result.access_kind = KIND_DEVICE;
            end else if (is_write) begin
                if (lo < IO_SWITCH_END) begin
                    result.access_kind = KIND_SWITCH;
                    case (lo[3:1])
                        3'd0:    state_next.store_80        = on;
                        3'd1:    state_next.aux_read        = on;
                        3'd2:    state_next.aux_write       = on;
                        3'd3:    state_next.internal_cx_rom = on;
                        3'd4:    state_next.alt_zero_page   = on;
                        3'd5:    state_next.slot_c3_rom     = on;
                        default: result.access_kind = KIND_UNHANDLED;
                    endcase
                end else begin
                    result.access_kind = KIND_UNHANDLED;
                end
            end else begin
                result.access_kind = KIND_STATUS;
                case (lo)
                    8'h11:   result.status_bit = state_cur.lc_bank2;
                    8'h12:   result.status_bit = state_cur.lc_read_ram;
                    8'h13:   result.status_bit = state_cur.aux_read;
                    8'h14:   result.status_bit = state_cur.aux_write;
                    8'h15:   result.status_bit = state_cur.internal_cx_rom;
                    8'h16:   result.status_bit = state_cur.alt_zero_page;
                    8'h17:   result.status_bit = state_cur.slot_c3_rom;
                    8'h18:   result.status_bit = state_cur.store_80;
                    8'h20:   result.access_kind = KIND_DEVICE;
                    default: result.access_kind = KIND_FLOATING;
                endcase
            end
        end else begin
            result.target_bank   = bank;
            result.write_blocked = is_write && (bank == BANK_ROM || bank == BANK_CARD);
            // Release expansion ROM on CFFF or on C3 mapped to internal ROM
            if (address == ADDR_CX_RELEASE || (pg == PAGE_C3 &&
                (state_cur.internal_cx_rom || !state_cur.slot_c3_rom))) begin
                state_next.card_expansion_rom = 1'b0;
            end
        end
    end

endmodule

// ===== src/iie_bank_switch_mmu_unit.sv =====
// Apple IIe style bank-switch MMU with language-card decoding.
// Input channel (s_*): one bus access per transaction, address in s_tdata,
// opcode and the write flag in s_tuser. Opcode 1 is a card claiming the
// C800-CFFF expansion ROM space; its result carries all fields at zero.
// Output channel (m_*): one result per access with the mapped bank, the
// ROM write-block flag, the access class, the status bit and the slot.
// An access passes the input register, then the result register, onto
// m_tvalid. Throughput: one access per cycle when not stalled, held by
// the single decode pass that reads the switch state and writes it back
// in the same cycle. Results leave in acceptance order.
// Reset (aresetn low, synchronous) empties both registers and restores the
// switches: language card writes RAM, bank 2 selected, everything else off.
// When the receiver stalls, the result register holds; one more access may
// sit in the input register, after which s_tready drops until m_tready.
module iie_bank_switch_mmu_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] address
    input  logic [1:0]  s_tuser,   // [0] opcode, [1] is_write
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [2:0] target_bank, [3] write_blocked,
                                   // [6:4] access_kind, [7] status_bit,
                                   // [10:8] slot_index, [15:11] zero
);
    import iie_bsm_pkg::*;

    logic        in_valid_reg;
    logic [15:0] in_addr_reg;
    logic        in_op_reg;
    logic        in_wr_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    state_t      state_reg;
    state_t      state_next;
    result_t     result;
    logic        advance;

    // Move the held access into the result register when there is room
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    iie_bsm_decode u_decode (
        .state_cur  (state_reg),
        .opcode     (in_op_reg),
        .address    (in_addr_reg),
        .is_write   (in_wr_reg),
        .result     (result),
        .state_next (state_next)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_addr_reg <= s_tdata;
            in_op_reg   <= s_tuser[0];
            in_wr_reg   <= s_tuser[1];
        end
    end

    // Switch state advances with each decoded access
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.slot_index, out_reg.status_bit,
                       out_reg.access_kind, out_reg.write_blocked, out_reg.target_bank};

endmodule

// ===== src/iie_bsm_checker.sv =====
`include "iie_bank_switch_mmu_unit_assert.svh"

module iie_bsm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    import iie_bsm_pkg::*;

    logic [2:0] bank_f;
    logic       blocked_f;
    logic [2:0] kind_f;
    logic       status_f;
    logic       in_seen;

    assign bank_f    = m_tdata[RES_BANK_LSB +: 3];
    assign blocked_f = m_tdata[RES_BLOCKED_BIT];
    assign kind_f    = m_tdata[RES_KIND_LSB +: 3];
    assign status_f  = m_tdata[RES_STATUS_BIT];
    assign in_seen   = s_tvalid && s_tready;

    // A stalled result holds its value
    `IIE_BSM_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

    // Only writes to ROM or card ROM are blocked
    `IIE_BSM_ASSERT_NOW(a_blocked_rom, aclk, aresetn, m_tvalid && blocked_f, bank_f == BANK_ROM || bank_f == BANK_CARD, "blocked write outside ROM banks")

    // I/O-page results map to main memory and are never blocked
    `IIE_BSM_ASSERT_NOW(a_io_main, aclk, aresetn, m_tvalid && kind_f != KIND_MEMORY, bank_f == BANK_MAIN && !blocked_f, "I/O access mapped off main")

    // A set status bit comes only from a status read
    `IIE_BSM_ASSERT_NOW(a_status_kind, aclk, aresetn, m_tvalid && status_f, kind_f == KIND_STATUS, "status bit on non-status result")

    // An accepted access passes the input register and then shows a result on m_tvalid
    `IIE_BSM_ASSERT_NEXT(a_result_follows, aclk, aresetn, in_seen, ##1 m_tvalid, "no result after accepted access")

endmodule

bind iie_bank_switch_mmu_unit iie_bsm_checker u_checker (.*);
